// ----- rtl/core/packet_fragmenter_defines.svh -----
// Assertion macros for the packet fragmenter.
// Used by pf_back under rtl/core; expects clock and reset in scope.
`ifndef PACKET_FRAGMENTER_DEFINES_SVH
`define PACKET_FRAGMENTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PF_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define PF_ASSERT(label, prop, msg)
`define PF_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ----- rtl/core/pf_pkg.sv -----
// Shared types and constants of the packet fragmenter.
// No dependencies; imported by every module of the block.
package pf_pkg;

   // block header size and smallest usable size limit
   localparam logic [15:0] HDR_LEN   = 16'd4;
   localparam logic [15:0] MIN_LIMIT = 16'd6;

   // default parameter values
   localparam int DEF_MAX_BLOCK   = 1024;
   localparam int DEF_QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLK_LIMIT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ID  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_ID   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_ID    = 4'd3;

   // configuration reset values
   localparam logic [10:0] RST_BLK_LIMIT = 11'd1024;
   localparam logic [15:0] RST_START_ID  = 16'd1;
   localparam logic [15:0] RST_PART_ID   = 16'd2;
   localparam logic [15:0] RST_END_ID    = 16'd3;

   typedef struct packed {
      logic [10:0] blk_limit;
      logic [15:0] start_id;
      logic [15:0] part_id;
      logic [15:0] end_id;
   } cfg_type;

   // one classified source byte, handed from front to back
   typedef struct packed {
      logic        err;        // length error result only
      logic        hdr;        // four header bytes come first
      logic        held_valid; // first length byte comes before data
      logic        last;       // final byte of the packet
      logic [7:0]  data;
      logic [7:0]  held;
      logic [15:0] hdr_len;
      logic [15:0] hdr_id;
   } cmd_type;

   // front parsing phase
   typedef enum logic [1:0] {
      PH_LEN_LO,
      PH_LEN_HI,
      PH_BODY
   } phase_type;

   // back output slot within one command
   typedef enum logic [2:0] {
      SL_LEN_LO,
      SL_LEN_HI,
      SL_ID_LO,
      SL_ID_HI,
      SL_HELD,
      SL_DATA
   } slot_type;

endpackage

// ----- rtl/core/packet_fragmenter.sv -----
// Path: a result passes the command queue and the registered output stage;
// the first length byte of a packet causes none. Throughput: one request per
// cycle unless the queue is full, one output byte per cycle unless rsp stalls;
// a request that opens a block yields 5 or 6 bytes, and the command queue
// (QUEUE_DEPTH) decides how far the request side runs ahead of header output.
// Reset: synchronous, clears parsing state and queue, loads register defaults.
module packet_fragmenter import pf_pkg::*; #(
   parameter int MAX_BLOCK   = DEF_MAX_BLOCK,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] data_byte
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] out_byte
   output logic [1:0]           rsp_tuser,   // [0] is_header, [1] length_error
   output logic                 rsp_tlast,   // last_byte
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;
   logic    q_full;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BLK_LIMIT: cfg_in.blk_limit = csr_data[10:0];
            CSR_START_ID:  cfg_in.start_id  = csr_data;
            CSR_PART_ID:   cfg_in.part_id   = csr_data;
            CSR_END_ID:    cfg_in.end_id    = csr_data;
            default:       cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blk_limit <= RST_BLK_LIMIT;
         cfg_ff.start_id  <= RST_START_ID;
         cfg_ff.part_id   <= RST_PART_ID;
         cfg_ff.end_id    <= RST_END_ID;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pf_front #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   pf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (q_full)
   );

   pf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/core/pf_queue.sv -----
// Small command queue between fragmenter front and back.
// Depends on pf_pkg for the command type.
module pf_queue import pf_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd,
   output logic    full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/core/pf_front.sv -----
// Fragmenter front: takes source bytes, tracks packet and block counts,
// and pushes one command per byte that yields output. Depends on pf_pkg.
module pf_front import pf_pkg::*; #(
   parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       q_full,
   output logic       push,
   output cmd_type    push_cmd
);

   phase_type   phase_ff, phase_in;
   logic [15:0] remain_ff, remain_in;       // source bytes still due in the packet
   logic [15:0] block_rem_ff, block_rem_in; // payload bytes still due in the block
   logic        pass_ff, pass_in;
   logic [7:0]  held_ff, held_in;

   logic        accept;
   logic [15:0] limit_raw;
   logic [15:0] limit;
   logic [15:0] room;
   logic [15:0] len_word;
   logic        last;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   // size limit saturated to the usable range
   always_comb begin
      limit_raw = {5'd0, cfg.blk_limit};
      limit     = limit_raw;
      if (limit_raw > 16'(MAX_BLOCK)) begin
         limit = 16'(MAX_BLOCK);
      end
      if (limit < MIN_LIMIT) begin
         limit = MIN_LIMIT;
      end
      room = limit - HDR_LEN;
   end

   assign len_word = {req_tdata, held_ff};
   assign last     = (remain_ff == 16'd1);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_LEN_LO: begin
            if (accept) phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            if (accept) phase_in = (len_word < HDR_LEN) ? PH_LEN_LO : PH_BODY;
         end
         PH_BODY: begin
            if (accept && last) phase_in = PH_LEN_LO;
         end
         default: phase_in = PH_LEN_LO;
      endcase
   end

   // counters and command
   always_comb begin
      remain_in    = remain_ff;
      block_rem_in = block_rem_ff;
      pass_in      = pass_ff;
      held_in      = held_ff;
      push         = 1'b0;
      push_cmd     = '0;
      case (phase_ff)
         PH_LEN_LO: begin
            if (accept) held_in = req_tdata;
         end
         PH_LEN_HI: begin
            if (accept) begin
               push          = 1'b1;
               push_cmd.held = held_ff;
               push_cmd.data = req_tdata;
               if (len_word < HDR_LEN) begin
                  // short length: one error result, packet dropped
                  push_cmd.err  = 1'b1;
                  push_cmd.last = 1'b1;
                  push_cmd.data = 8'd0;
                  block_rem_in  = '0;
                  pass_in       = 1'b0;
               end else if (len_word < limit) begin
                  push_cmd.held_valid = 1'b1;
                  pass_in             = 1'b1;
                  block_rem_in        = '0;
                  remain_in           = len_word - 16'd2;
               end else begin
                  // first block is always full and carries the start id
                  push_cmd.held_valid = 1'b1;
                  push_cmd.hdr        = 1'b1;
                  push_cmd.hdr_len    = limit;
                  push_cmd.hdr_id     = cfg.start_id;
                  pass_in             = 1'b0;
                  block_rem_in        = room - 16'd2;
                  remain_in           = len_word - 16'd2;
               end
            end
         end
         PH_BODY: begin
            if (accept) begin
               push          = 1'b1;
               push_cmd.data = req_tdata;
               push_cmd.last = last;
               if (!pass_ff && block_rem_ff == '0) begin
                  push_cmd.hdr = 1'b1;
                  if (remain_ff > room) begin
                     push_cmd.hdr_len = limit;
                     push_cmd.hdr_id  = cfg.part_id;
                     block_rem_in     = room - 16'd1;
                  end else begin
                     push_cmd.hdr_len = remain_ff + HDR_LEN;
                     push_cmd.hdr_id  = cfg.end_id;
                     block_rem_in     = remain_ff - 16'd1;
                  end
               end else if (!pass_ff) begin
                  block_rem_in = block_rem_ff - 16'd1;
               end
               remain_in = remain_ff - 16'd1;
               if (last) begin
                  block_rem_in = '0;
                  pass_in      = 1'b0;
               end
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEN_LO;
         remain_ff    <= '0;
         block_rem_ff <= '0;
         pass_ff      <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remain_ff    <= remain_in;
         block_rem_ff <= block_rem_in;
         pass_ff      <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

// ----- rtl/core/pf_back.sv -----
// Fragmenter back: expands queued commands into output bytes through
// a registered output stage. Depends on pf_pkg and the assertion macros.
`include "packet_fragmenter_defines.svh"
module pf_back import pf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] is_header, [1] length_error
   output logic       rsp_tlast    // last_byte
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       hdr_ff, hdr_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;
   logic       active_ff, active_in;
   slot_type   step_ff, step_in;

   logic       load;
   logic       emit;
   slot_type   cur_slot;
   slot_type   next_slot;

   assign load = !rsp_valid_ff || rsp_tready;
   assign emit = head_valid && load;
   assign pop  = emit && (cur_slot == SL_DATA);

   // slot being sent: resume mid-command or start a new one
   always_comb begin
      if (active_ff) begin
         cur_slot = step_ff;
      end else if (head_cmd.hdr) begin
         cur_slot = SL_LEN_LO;
      end else if (head_cmd.held_valid) begin
         cur_slot = SL_HELD;
      end else begin
         cur_slot = SL_DATA;
      end
   end

   // slot order and output byte select
   always_comb begin
      next_slot = SL_DATA;
      byte_in   = head_cmd.data;
      case (cur_slot)
         SL_LEN_LO: begin
            next_slot = SL_LEN_HI;
            byte_in   = head_cmd.hdr_len[7:0];
         end
         SL_LEN_HI: begin
            next_slot = SL_ID_LO;
            byte_in   = head_cmd.hdr_len[15:8];
         end
         SL_ID_LO: begin
            next_slot = SL_ID_HI;
            byte_in   = head_cmd.hdr_id[7:0];
         end
         SL_ID_HI: begin
            next_slot = head_cmd.held_valid ? SL_HELD : SL_DATA;
            byte_in   = head_cmd.hdr_id[15:8];
         end
         SL_HELD: begin
            next_slot = SL_DATA;
            byte_in   = head_cmd.held;
         end
         default: begin
            next_slot = SL_DATA;
            byte_in   = head_cmd.data;
         end
      endcase
   end

   // output register and slot tracking
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      active_in    = active_ff;
      step_in      = step_ff;
      hdr_in       = (cur_slot == SL_LEN_LO) || (cur_slot == SL_LEN_HI) ||
                     (cur_slot == SL_ID_LO) || (cur_slot == SL_ID_HI);
      last_in      = (cur_slot == SL_DATA) && head_cmd.last;
      err_in       = (cur_slot == SL_DATA) && head_cmd.err;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (cur_slot == SL_DATA) begin
            active_in = 1'b0;
         end else begin
            active_in = 1'b1;
            step_in   = next_slot;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         step_ff      <= SL_LEN_LO;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         hdr_ff  <= hdr_in;
         last_ff <= last_in;
         err_ff  <= err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {err_ff, hdr_ff};
   assign rsp_tlast  = last_ff;

   // a command in progress stays at the queue head until its data byte
   `PF_ASSERT(a_active_has_cmd, active_ff |-> head_valid, "command left queue mid-expansion")
   // a resumed header slot belongs to a command that has a header
   `PF_ASSERT(a_hdr_slot_has_hdr, (active_ff && (step_ff == SL_LEN_HI || step_ff == SL_ID_LO || step_ff == SL_ID_HI)) |-> head_cmd.hdr, "header slot without header")
   // an error result always ends the packet and is never a header byte
   `PF_ASSERT_NEVER(a_err_shape, rsp_valid_ff && err_ff && (!last_ff || hdr_ff), "malformed error result")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for packet_fragmenter: directed table, then random packets.
// Depends on pf_pkg and the packet_fragmenter RTL; predicts every output byte itself.
module tb_top;
   import pf_pkg::*;

   localparam int MAX_BLOCK   = DEF_MAX_BLOCK;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 12;
   localparam int RANDOM_BYTES = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 4'd15;

   // one output byte as the block presents it
   typedef struct packed {
      logic [7:0] data;
      logic       hdr;
      logic       last;
      logic       err;
   } frag_byte_type;

   // one row of the directed table: a register write or a source byte
   typedef struct packed {
      logic                 is_cfg;
      logic [CSR_IDX_W-1:0] idx;
      logic [15:0]          value;
      logic                 typed;
      frag_byte_type        want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = 8'h00;   // [7:0] data_byte
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;           // [7:0] out_byte
   logic [1:0]           rsp_tuser;           // [0] is_header, [1] length_error
   logic                 rsp_tlast;           // last_byte
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BLK_LIMIT;
   logic [15:0]          csr_data = 16'h0000;

   packet_fragmenter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock, period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // register copies and parsing state of the predictor
   logic [10:0] cfg_limit    = RST_BLK_LIMIT;
   logic [15:0] cfg_start_id = RST_START_ID;
   logic [15:0] cfg_part_id  = RST_PART_ID;
   logic [15:0] cfg_end_id   = RST_END_ID;
   logic [15:0] src_pos      = '0;
   logic [15:0] pkt_len      = '0;
   logic [7:0]  len_lo_held  = '0;
   logic [15:0] blk_left     = '0;
   logic        pass_mode    = 1'b0;

   frag_byte_type expected_out[$];
   int  mismatches   = 0;
   int  rsp_count    = 0;
   int  cycle_count  = 0;
   int  bytes_sent   = 0;
   int  rx_stall     = 0;
   bit  quiet        = 1'b0;

   // gap length: mostly short, a few long
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   // size limit clamped to the usable range
   function automatic logic [15:0] limit_now();
      logic [15:0] lim;
      lim = 16'(cfg_limit);
      if (lim > MAX_BLOCK) lim = 16'(MAX_BLOCK);
      if (lim < MIN_LIMIT) lim = MIN_LIMIT;
      return lim;
   endfunction

   function automatic void emit(input logic [7:0] d, input logic h, input logic l,
                                input logic e);
      expected_out.push_back(frag_byte_type'{data: d, hdr: h, last: l, err: e});
   endfunction

   // four header bytes: block length then id, both little-endian
   function automatic void emit_header(input logic [15:0] payload, input logic [15:0] id);
      logic [15:0] blen;
      blen = payload + HDR_LEN;
      emit(blen[7:0], 1'b1, 1'b0, 1'b0);
      emit(blen[15:8], 1'b1, 1'b0, 1'b0);
      emit(id[7:0], 1'b1, 1'b0, 1'b0);
      emit(id[15:8], 1'b1, 1'b0, 1'b0);
   endfunction

   // expected output bytes for one accepted source byte
   function automatic void fragment_byte(input logic [7:0] b);
      logic [15:0] lim;
      logic [15:0] room;
      logic [15:0] len;
      logic [15:0] left;
      logic        fin;
      lim  = limit_now();
      room = lim - HDR_LEN;
      if (src_pos == 16'd0) begin
         len_lo_held = b;
         src_pos     = 16'd1;
      end else if (src_pos == 16'd1) begin
         len = {b, len_lo_held};
         if (len < HDR_LEN) begin
            // short length: packet dropped with an error byte
            src_pos   = 16'd0;
            blk_left  = 16'd0;
            pass_mode = 1'b0;
            emit(8'h00, 1'b0, 1'b1, 1'b1);
         end else begin
            pkt_len = len;
            src_pos = 16'd2;
            if (len < lim) begin
               pass_mode = 1'b1;
               blk_left  = 16'd0;
               emit(len_lo_held, 1'b0, 1'b0, 1'b0);
               emit(b, 1'b0, 1'b0, 1'b0);
            end else begin
               pass_mode = 1'b0;
               emit_header(room, cfg_start_id);
               emit(len_lo_held, 1'b0, 1'b0, 1'b0);
               emit(b, 1'b0, 1'b0, 1'b0);
               blk_left = room - 16'd2;
            end
         end
      end else begin
         // a new block opens with a part or end header
         if (!pass_mode && blk_left == 16'd0) begin
            left = pkt_len - src_pos;
            if (left > room) begin
               emit_header(room, cfg_part_id);
               blk_left = room;
            end else begin
               emit_header(left, cfg_end_id);
               blk_left = left;
            end
         end
         src_pos = src_pos + 16'd1;
         fin     = (src_pos == pkt_len);
         emit(b, 1'b0, fin, 1'b0);
         if (!pass_mode && blk_left > 16'd0) blk_left = blk_left - 16'd1;
         if (fin) begin
            src_pos   = 16'd0;
            blk_left  = 16'd0;
            pass_mode = 1'b0;
         end
      end
   endfunction

   // directed table rows
   function automatic stim_row_type byte_row(input logic [7:0] b);
      return stim_row_type'{is_cfg: 1'b0, idx: CSR_BLK_LIMIT, value: {8'h00, b},
                            typed: 1'b0, want: '0};
   endfunction

   function automatic stim_row_type checked_row(input logic [7:0] b, input logic [7:0] d,
                                                input logic l, input logic e);
      return stim_row_type'{is_cfg: 1'b0, idx: CSR_BLK_LIMIT, value: {8'h00, b}, typed: 1'b1,
                            want: frag_byte_type'{data: d, hdr: 1'b0, last: l, err: e}};
   endfunction

   function automatic stim_row_type cfg_row(input logic [CSR_IDX_W-1:0] i,
                                            input logic [15:0] v);
      return stim_row_type'{is_cfg: 1'b1, idx: i, value: v, typed: 1'b0, want: '0};
   endfunction

   // one request on the source side, predicted once accepted
   task automatic send_byte(input logic [7:0] b, input bit typed, input frag_byte_type want);
      int gap;
      int n_before;
      gap = (!quiet && $urandom_range(0, 9) < 4) ? draw_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      n_before = expected_out.size();
      fragment_byte(b);
      // a typed row replaces the single predicted byte
      if (typed) begin
         while (expected_out.size() > n_before) void'(expected_out.pop_back());
         expected_out.push_back(want);
      end
   endtask

   // register write; caller lowers csr_valid after the last of a group
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BLK_LIMIT: cfg_limit    = value[10:0];
         CSR_START_ID:  cfg_start_id = value;
         CSR_PART_ID:   cfg_part_id  = value;
         CSR_END_ID:    cfg_end_id   = value;
         default: ;
      endcase
   endtask

   // sender holds off until every expected byte has come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_phase(input logic [15:0] lim, input logic [15:0] sid,
                            input logic [15:0] pid, input logic [15:0] eid);
      wait_idle();
      if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, 16'($urandom_range(0, 65535)));
      write_reg(CSR_BLK_LIMIT, lim);
      write_reg(CSR_START_ID, sid);
      write_reg(CSR_PART_ID, pid);
      write_reg(CSR_END_ID, eid);
      csr_valid <= 1'b0;
   endtask

   // length bytes then a body of random bytes
   task automatic send_packet(input logic [15:0] len, input int body);
      send_byte(len[7:0], 1'b0, '0);
      send_byte(len[15:8], 1'b0, '0);
      for (int k = 0; k < body; k++) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   function automatic logic [15:0] pick_id();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // result side: random stalls unless in a quiet stretch
   always @(posedge clock) begin
      if (rx_stall > 0) begin
         rsp_tready <= 1'b0;
         rx_stall   <= rx_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0) rx_stall <= draw_gap();
      end
   end

   // compare each output byte with the oldest expectation
   always @(posedge clock) begin : rsp_check
      frag_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_out.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("output %0d: unexpected byte %02h hdr %b last %b err %b", rsp_count,
                        rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
         end else begin
            want = expected_out.pop_front();
            if (rsp_tdata !== want.data || rsp_tuser[0] !== want.hdr ||
                rsp_tlast !== want.last || rsp_tuser[1] !== want.err) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("output %0d: expected %02h hdr %b last %b err %b, got %02h hdr %b last %b err %b",
                           rsp_count, want.data, want.hdr, want.last, want.err,
                           rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** packet_fragmenter: FAILED **");
         $finish;
      end
   end

   initial begin
      stim_row_type dir_tab[$];
      stim_row_type row;
      logic [15:0]  lim_pick;
      logic [15:0]  len;
      int           body;
      int           r;
      int           phase_start;
      int           phase_len;

      // short length three, then zero: both dropped with an error byte
      dir_tab.push_back(byte_row(8'h03));
      dir_tab.push_back(checked_row(8'h00, 8'h00, 1'b1, 1'b1));
      dir_tab.push_back(byte_row(8'h00));
      dir_tab.push_back(checked_row(8'h00, 8'h00, 1'b1, 1'b1));
      // length five passes through at the reset limit
      dir_tab.push_back(byte_row(8'h05));
      dir_tab.push_back(byte_row(8'h00));
      dir_tab.push_back(checked_row(8'hFF, 8'hFF, 1'b0, 1'b0));
      dir_tab.push_back(checked_row(8'h00, 8'h00, 1'b0, 1'b0));
      dir_tab.push_back(checked_row(8'h80, 8'h80, 1'b1, 1'b0));
      // registers at their extremes, unused index ignored
      dir_tab.push_back(cfg_row(CSR_BLK_LIMIT, 16'd5));
      dir_tab.push_back(cfg_row(CSR_START_ID, 16'hFFFF));
      dir_tab.push_back(cfg_row(CSR_PART_ID, 16'h0000));
      dir_tab.push_back(cfg_row(CSR_END_ID, 16'hA55A));
      dir_tab.push_back(cfg_row(CSR_UNUSED, 16'hFFFF));
      // limit five acts as six: length nine cut into two-byte blocks and a final one-byte block
      dir_tab.push_back(byte_row(8'h09));
      dir_tab.push_back(byte_row(8'h00));
      dir_tab.push_back(byte_row(8'h00));
      dir_tab.push_back(byte_row(8'hFF));
      dir_tab.push_back(byte_row(8'h01));
      dir_tab.push_back(byte_row(8'h80));
      dir_tab.push_back(byte_row(8'h7F));
      dir_tab.push_back(byte_row(8'hAA));
      dir_tab.push_back(byte_row(8'h55));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < dir_tab.size(); i++) begin
         row = dir_tab[i];
         if (row.is_cfg) begin
            if (i > 0 && !dir_tab[i-1].is_cfg) wait_idle();
            write_reg(row.idx, row.value);
            if (i + 1 == dir_tab.size() || !dir_tab[i+1].is_cfg) csr_valid <= 1'b0;
         end else begin
            send_byte(row.value[7:0], row.typed, row.want);
         end
      end

      // random phases, each under its own register setting
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RANDOM_BYTES) begin
         case ($urandom_range(0, 8))
            0:       lim_pick = 16'd5;
            1:       lim_pick = 16'd6;
            2:       lim_pick = 16'd7;
            3:       lim_pick = 16'd8;
            4:       lim_pick = 16'($urandom_range(9, 40));
            5:       lim_pick = 16'd1024;
            6:       lim_pick = 16'd2047;
            7:       lim_pick = 16'd0;
            default: lim_pick = 16'($urandom_range(0, 65535));
         endcase
         set_phase(lim_pick, pick_id(), pick_id(), pick_id());
         quiet = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(15, 30);
         r = bytes_sent;
         while (bytes_sent - r < phase_len) begin
            if ($urandom_range(0, 99) < 12) begin
               send_packet(16'($urandom_range(0, 3)), 0);
            end else begin
               if ($urandom_range(0, 99) < 25 && limit_now() <= 16'd40)
                  len = limit_now() - 16'd1 + 16'($urandom_range(0, 2));
               else
                  len = 16'($urandom_range(4, 40));
               body = len - 2;
               send_packet(len, body);
            end
         end
         // finish any packet left open so the block ends idle
         while (src_pos != 16'd0) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
      quiet = 1'b0;

      // opening of a packet of the largest block size, limit above the maximum;
      // the run ends inside it
      set_phase(16'd2047, pick_id(), pick_id(), pick_id());
      send_packet(16'(MAX_BLOCK), 8);

      req_tvalid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (SETTLE * 2) @(posedge clock);
      if (mismatches == 0 && expected_out.size() == 0)
         $display("** packet_fragmenter: PASSED **");
      else
         $display("** packet_fragmenter: FAILED **");
      $finish;
   end

endmodule
